// File: design/utf_pkg.sv
package utf_pkg;

	// input and result items
	typedef struct packed {
		logic [15:0] code_unit;
		logic        string_end;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_value;
		logic        run_last;
		logic        string_done;
		logic        error;
	} out_item_t;

	// results produced by one input item, in emit order from index 0
	typedef struct packed {
		logic [1:0]          cnt;
		out_item_t [2:0]     res;
	} res_group_t;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic [15:0] ASCII_LIMIT    = 16'h0080;
	localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

	localparam logic [7:0] BYTE_CONT_MIN = 8'h80;
	localparam logic [7:0] BYTE_LEAD2    = 8'hC0;
	localparam logic [7:0] BYTE_LEAD3    = 8'hE0;
	localparam logic [7:0] BYTE_LEAD4    = 8'hF0;
	localparam logic [7:0] BYTE_BAD      = 8'hF8;
	localparam logic [1:0] CONT_TAG      = 2'b10;

	localparam logic [2:0] PFX_LEAD2 = 3'b110;
	localparam logic [3:0] PFX_LEAD3 = 4'b1110;

	localparam out_item_t ERR_ITEM = '{
		out_value: 16'h0000, run_last: 1'b1, string_done: 1'b1, error: 1'b1};

endpackage

// File: design/utf_core.sv
module utf_core import utf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_data,
	input  in_item_t   item,
	input  logic       advance,
	output res_group_t grp
);

	logic        dir_q;
	logic [1:0]  pend_q;
	logic [15:0] acc_q;
	logic        poison_q;

	logic [1:0]  pend_d;
	logic [15:0] acc_d;
	logic        poison_d;

	logic [15:0] c;
	logic [7:0]  b;
	logic        e;
	logic [15:0] acc_shift;
	logic        fail;

	assign c         = item.code_unit;
	assign b         = item.code_unit[7:0];
	assign e         = item.string_end;
	assign acc_shift = {acc_q[9:0], b[5:0]};

	always_comb begin
		pend_d   = pend_q;
		acc_d    = acc_q;
		poison_d = poison_q;
		fail     = 1'b0;
		grp      = '0;
		if (poison_q) begin
			// swallow until the string ends
			if (e) begin
				poison_d = 1'b0;
			end
		end else if (dir_q == DIR_ENCODE) begin
			if (c == 16'h0000) begin
				fail = 1'b1;
			end else if (c < ASCII_LIMIT) begin
				grp.cnt    = 2'd1;
				grp.res[0] = '{out_value: c, run_last: 1'b1, string_done: e, error: 1'b0};
			end else if (c < TWO_BYTE_LIMIT) begin
				grp.cnt    = 2'd2;
				grp.res[0] = '{out_value: {8'h00, PFX_LEAD2, c[10:6]},
					run_last: 1'b0, string_done: 1'b0, error: 1'b0};
				grp.res[1] = '{out_value: {8'h00, CONT_TAG, c[5:0]},
					run_last: 1'b1, string_done: e, error: 1'b0};
			end else begin
				grp.cnt    = 2'd3;
				grp.res[0] = '{out_value: {8'h00, PFX_LEAD3, c[15:12]},
					run_last: 1'b0, string_done: 1'b0, error: 1'b0};
				grp.res[1] = '{out_value: {8'h00, CONT_TAG, c[11:6]},
					run_last: 1'b0, string_done: 1'b0, error: 1'b0};
				grp.res[2] = '{out_value: {8'h00, CONT_TAG, c[5:0]},
					run_last: 1'b1, string_done: e, error: 1'b0};
			end
		end else if (pend_q == 2'd0) begin
			if (b < BYTE_CONT_MIN) begin
				grp.cnt    = 2'd1;
				grp.res[0] = '{out_value: {8'h00, b}, run_last: 1'b1,
					string_done: e, error: 1'b0};
			end else if (b < BYTE_LEAD2 || b >= BYTE_BAD) begin
				fail = 1'b1;
			end else begin
				if (b < BYTE_LEAD3) begin
					acc_d  = {11'd0, b[4:0]};
					pend_d = 2'd1;
				end else if (b < BYTE_LEAD4) begin
					acc_d  = {12'd0, b[3:0]};
					pend_d = 2'd2;
				end else begin
					acc_d  = {13'd0, b[2:0]};
					pend_d = 2'd3;
				end
				// a lead byte cannot end a string
				fail = e;
			end
		end else if (b[7:6] != CONT_TAG) begin
			fail = 1'b1;
		end else if (pend_q == 2'd1) begin
			pend_d     = 2'd0;
			acc_d      = 16'h0000;
			grp.cnt    = 2'd1;
			grp.res[0] = '{out_value: acc_shift, run_last: 1'b1, string_done: e, error: 1'b0};
		end else begin
			pend_d = pend_q - 2'd1;
			acc_d  = acc_shift;
			fail   = e;
		end

		if (fail) begin
			pend_d     = 2'd0;
			acc_d      = 16'h0000;
			poison_d   = ~e;
			grp.cnt    = 2'd1;
			grp.res[0] = ERR_ITEM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= DIR_ENCODE;
			pend_q   <= 2'd0;
			acc_q    <= 16'h0000;
			poison_q <= 1'b0;
		end else if (cfg_we) begin
			dir_q    <= cfg_data;
			pend_q   <= 2'd0;
			acc_q    <= 16'h0000;
			poison_q <= 1'b0;
		end else if (advance) begin
			pend_q   <= pend_d;
			acc_q    <= acc_d;
			poison_q <= poison_d;
		end
	end

endmodule

// File: design/utf_emit.sv
module utf_emit import utf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  res_group_t grp,
	input  logic       load,
	output logic       grp_ready,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data
);

	logic [1:0]      cnt_q;
	out_item_t [2:0] slot_q;
	logic            take;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[0];
	assign take      = out_valid & ~out_stall;
	// free when empty or when the last held item leaves this cycle
	assign grp_ready = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= grp.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= grp.res;
		end else if (take) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

// File: design/utf16_utf8_transcoder_top.sv
// channel   signals                           direction
// in        in_valid, in_stall, in_data       item in, stall out
// out       out_valid, out_stall, out_data    item out, stall in
// cfg       cfg_we, cfg_data                  direction register write
//
// results leave at one per cycle while out_stall is low; an item giving one result
// (or none) is then taken every cycle, an encoded unit of two or three bytes holds
// the input while the result shift register drains.
// reset clears the direction (encode), the decode state and all valid flags.
// out_stall reaches in_stall the same cycle once the input register is full.
module utf16_utf8_transcoder_top import utf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_data
);

	logic       valid_s1;
	in_item_t   item_s1;
	logic       grp_ready;
	logic       load;
	logic       accept;
	res_group_t grp;

	assign load     = valid_s1 & grp_ready;
	assign in_stall = valid_s1 & ~load;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	utf_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.item    (item_s1),
		.advance (load),
		.grp     (grp)
	);

	utf_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.grp      (grp),
		.load     (load),
		.grp_ready(grp_ready),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// File: tb/utf_checker.sv
`timescale 1ns / 100ps

module utf_checker import utf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_data,
	output int        fail_count,
	output int        outstanding,
	output int        results_seen
);

	logic        dir = DIR_ENCODE;
	logic [1:0]  bytes_left = '0;
	logic [15:0] acc = '0;
	logic        poisoned = 1'b0;

	out_item_t   expected_q[$];
	out_item_t   exp_item;
	int          n_fail = 0;
	int          n_seen = 0;

	function automatic void push_result(logic [15:0] v, logic last, logic done, logic err);
		out_item_t r;
		r.out_value   = v;
		r.run_last    = last;
		r.string_done = done;
		r.error       = err;
		expected_q.push_back(r);
	endfunction

	// an error drops the sequence and poisons the string unless it ends here
	function automatic void push_error(logic str_end);
		bytes_left = '0;
		acc        = '0;
		poisoned   = !str_end;
		expected_q.push_back(ERR_ITEM);
	endfunction

	function automatic void encode_unit(logic [15:0] c, logic e);
		if (c == '0) begin
			push_error(e);
		end else if (c < ASCII_LIMIT) begin
			push_result(c, 1'b1, e, 1'b0);
		end else if (c < TWO_BYTE_LIMIT) begin
			push_result({8'h00, BYTE_LEAD2 | {3'b000, c[10:6]}}, 1'b0, 1'b0, 1'b0);
			push_result({8'h00, BYTE_CONT_MIN | {2'b00, c[5:0]}}, 1'b1, e, 1'b0);
		end else begin
			push_result({8'h00, BYTE_LEAD3 | {4'h0, c[15:12]}}, 1'b0, 1'b0, 1'b0);
			push_result({8'h00, BYTE_CONT_MIN | {2'b00, c[11:6]}}, 1'b0, 1'b0, 1'b0);
			push_result({8'h00, BYTE_CONT_MIN | {2'b00, c[5:0]}}, 1'b1, e, 1'b0);
		end
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic e);
		if (bytes_left == 2'd0) begin
			if (b < BYTE_CONT_MIN) begin
				push_result({8'h00, b}, 1'b1, e, 1'b0);
			end else if (b < BYTE_LEAD2 || b >= BYTE_BAD) begin
				push_error(e);
			end else begin
				if (b < BYTE_LEAD3) begin
					acc        = {11'd0, b[4:0]};
					bytes_left = 2'd1;
				end else if (b < BYTE_LEAD4) begin
					acc        = {12'd0, b[3:0]};
					bytes_left = 2'd2;
				end else begin
					acc        = {13'd0, b[2:0]};
					bytes_left = 2'd3;
				end
				if (e)
					push_error(e);
			end
		end else if (b[7:6] != CONT_TAG) begin
			push_error(e);
		end else begin
			// only the low 16 bits of the code point survive
			acc        = {acc[9:0], b[5:0]};
			bytes_left = bytes_left - 2'd1;
			if (bytes_left == 2'd0) begin
				push_result(acc, 1'b1, e, 1'b0);
				acc = '0;
			end else if (e) begin
				push_error(e);
			end
		end
	endfunction

	function automatic void transcode_item(in_item_t it);
		if (poisoned) begin
			if (it.string_end)
				poisoned = 1'b0;
		end else if (dir == DIR_ENCODE) begin
			encode_unit(it.code_unit, it.string_end);
		end else begin
			decode_byte(it.code_unit[7:0], it.string_end);
		end
	endfunction

	function automatic void report(logic have_exp, out_item_t e, out_item_t a);
		n_fail++;
		if (n_fail <= 10) begin
			if (!have_exp)
				$display("%0t: unexpected result value=%h last=%b done=%b err=%b",
					$time, a.out_value, a.run_last, a.string_done, a.error);
			else
				$display("%0t: expected value=%h last=%b done=%b err=%b, got value=%h last=%b done=%b err=%b",
					$time, e.out_value, e.run_last, e.string_done, e.error,
					a.out_value, a.run_last, a.string_done, a.error);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir        = DIR_ENCODE;
			bytes_left = '0;
			acc        = '0;
			poisoned   = 1'b0;
			expected_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				n_seen++;
				if (expected_q.size() == 0) begin
					report(1'b0, ERR_ITEM, out_data);
				end else begin
					exp_item = expected_q.pop_front();
					if (out_data.out_value !== exp_item.out_value ||
						out_data.run_last !== exp_item.run_last ||
						out_data.string_done !== exp_item.string_done ||
						out_data.error !== exp_item.error)
						report(1'b1, exp_item, out_data);
				end
			end
			// a direction write also cuts off any partial string
			if (cfg_we) begin
				dir        = cfg_data;
				bytes_left = '0;
				acc        = '0;
				poisoned   = 1'b0;
			end
			if (in_valid && !in_stall)
				transcode_item(in_data);
		end
		fail_count   <= n_fail;
		outstanding  <= expected_q.size();
		results_seen <= n_seen;
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top import utf_pkg::*; ();

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_we = 1'b0;
	logic      cfg_data = 1'b0;

	int        fail_count;
	int        outstanding;
	int        results_seen;
	int        items_sent = 0;
	int        phase_end;
	logic      calm = 1'b0;

	utf16_utf8_transcoder_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	utf_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 14);
	end

	// called at a rising edge; returns at the edge where the item is taken
	task automatic send_item(input logic [15:0] unit, input logic last);
		if (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{code_unit: unit, string_end: last};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// wait until the block is drained, then write the direction
	task automatic set_direction(input logic d);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= d;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	function automatic logic [15:0] random_unit();
		int pick;
		pick = $urandom_range(99);
		if (pick < 4)
			return 16'h0000;
		else if (pick < 30)
			return 16'($urandom_range(1, 16'h007F));
		else if (pick < 55)
			return 16'($urandom_range(16'h0080, 16'h07FF));
		else
			return 16'($urandom_range(16'h0800, 16'hFFFF));
	endfunction

	// mostly well-formed utf-8 sequences, some noise and broken ones
	task automatic send_utf8_seq();
		int         len;
		int         cut;
		logic [7:0] b;
		logic       fin;
		logic       broken;
		if ($urandom_range(99) < 10) begin
			send_item(16'($urandom_range(16'hFFFF)), $urandom_range(3) == 0);
			return;
		end
		len    = $urandom_range(1, 4);
		fin    = ($urandom_range(2) == 0);
		broken = (len > 1) && ($urandom_range(99) < 10);
		cut    = $urandom_range(1, len - 1);
		for (int k = 0; k < len; k++) begin
			if (k == 0) begin
				case (len)
					1: b = 8'($urandom_range(127));
					2: b = BYTE_LEAD2 | 8'($urandom_range(31));
					3: b = BYTE_LEAD3 | 8'($urandom_range(15));
					default: b = BYTE_LEAD4 | 8'($urandom_range(7));
				endcase
			end else begin
				b = BYTE_CONT_MIN | 8'($urandom_range(63));
			end
			if (broken && k == cut) begin
				if ($urandom_range(1))
					send_item({8'($urandom_range(255)), 8'($urandom_range(255))}, fin);
				else
					send_item({8'($urandom_range(255)), b}, 1'b1);
				return;
			end
			send_item({8'($urandom_range(255)), b}, (k == len - 1) ? fin : 1'b0);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// encode after reset: range edges, zero unit with and without string end
		send_item(16'h007F, 1'b0);
		send_item(16'h0080, 1'b0);
		send_item(16'h07FF, 1'b0);
		send_item(16'h0800, 1'b0);
		send_item(16'hFFFF, 1'b1);
		send_item(16'h0000, 1'b0);
		send_item(16'h1234, 1'b1);
		send_item(16'h0000, 1'b1);
		send_item(16'h0001, 1'b1);

		// decode: ignored high byte, overlong zero, 3 and 4 byte forms, errors
		set_direction(DIR_DECODE);
		send_item(16'hFF41, 1'b1);
		send_item(16'h00C0, 1'b0);
		send_item(16'h0080, 1'b1);
		send_item(16'h00E2, 1'b0);
		send_item(16'h0082, 1'b0);
		send_item(16'h00AC, 1'b1);
		send_item(16'h00F7, 1'b0);
		send_item(16'h00BF, 1'b0);
		send_item(16'h00BF, 1'b0);
		send_item(16'h00BF, 1'b1);
		send_item(16'h0080, 1'b0);
		send_item(16'h0041, 1'b1);
		send_item(16'h00F8, 1'b1);
		send_item(16'h00C3, 1'b1);
		send_item(16'h00E2, 1'b0);
		send_item(16'h0041, 1'b1);
		send_item(16'h00C3, 1'b0);

		// random phases; a write may cut off a partial string
		set_direction(DIR_ENCODE);
		phase_end = items_sent + 60;
		while (items_sent < phase_end)
			send_item(random_unit(), $urandom_range(3) == 0);

		set_direction(DIR_DECODE);
		phase_end = items_sent + 70;
		while (items_sent < phase_end)
			send_utf8_seq();

		// no idling on either side for this stretch
		calm <= 1'b1;
		set_direction(DIR_ENCODE);
		phase_end = items_sent + 60;
		while (items_sent < phase_end)
			send_item(random_unit(), $urandom_range(3) == 0);
		calm <= 1'b0;

		set_direction(DIR_DECODE);
		phase_end = items_sent + 70;
		while (items_sent < phase_end)
			send_utf8_seq();

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d items through six direction phases, encode and decode", items_sent);
		$display("checked %0d results, %0d mismatches", results_seen, fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("[utf16_utf8_transcoder_top] OK");
		else
			$display("[utf16_utf8_transcoder_top] ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results still expected", outstanding);
		$display("[utf16_utf8_transcoder_top] ERROR");
		$finish;
	end

endmodule

// File: utf16_utf8_transcoder_top.f
design/utf_pkg.sv
design/utf_core.sv
design/utf_emit.sv
design/utf16_utf8_transcoder_top.sv
tb/utf_checker.sv
tb/tb_top.sv
